/* rtl/core/fet_pkg.sv */
package fet_pkg;

  localparam int KEY_W     = 64;
  localparam int PORT_PL_W = 64;
  localparam int RET_W     = 7;
  localparam logic [RET_W-1:0] RET_RESET = 7'd64;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE,
    ST_EVICT
  } state_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic respond;
    logic write;
    logic evict;
  } cmd_t;

  typedef struct packed {
    logic mode;
    logic scan_done;
    logic over_limit;
  } status_t;

endpackage

/* rtl/core/fet_ram.sv */
module fet_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/core/fet_ctrl.sv */
module fet_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  fet_pkg::status_t sts,
  output fet_pkg::cmd_t    cmd
);
  import fet_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts.scan_done) state_nxt = sts.mode ? ST_IDLE : ST_WRITE;
      end
      ST_WRITE: begin
        state_nxt = ST_EVICT;
      end
      ST_EVICT: begin
        if (!sts.over_limit) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ST_SCAN: begin
        cmd.scan    = 1'b1;
        cmd.respond = sts.scan_done && sts.mode;
      end
      ST_WRITE: begin
        cmd.write = 1'b1;
      end
      ST_EVICT: begin
        cmd.evict = 1'b1;
      end
      default: busy = 1'b1;
    endcase
  end

endmodule

/* rtl/core/fet_dp.sv */
module fet_dp #(
  parameter int CAPACITY     = 64,
  parameter int PAYLOAD_BITS = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  fet_pkg::cmd_t                  cmd,
  output fet_pkg::status_t               sts,
  input  logic                           in_mode,
  input  logic [fet_pkg::KEY_W-1:0]      in_key,
  input  logic [fet_pkg::PORT_PL_W-1:0]  in_payload,
  output logic                           out_valid,
  output logic                           out_hit,
  output logic [fet_pkg::PORT_PL_W-1:0]  out_found_payload,
  input  logic                           cfg_we,
  input  logic [fet_pkg::RET_W-1:0]      cfg_wdata
);
  import fet_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int LW = (CW > RET_W) ? CW : RET_W;

  function automatic logic [AW-1:0] inc_slot(input logic [AW-1:0] p);
    return (p == AW'(CAPACITY - 1)) ? '0 : p + AW'(1);
  endfunction

  logic                    mode_r, mode_nxt;
  logic [KEY_W-1:0]        key_r, key_nxt;
  logic [PAYLOAD_BITS-1:0] pay_r, pay_nxt;
  logic [CW-1:0]           scan_cnt_r, scan_cnt_nxt;
  logic [AW-1:0]           scan_ptr_r, scan_ptr_nxt;
  logic [AW-1:0]           rd_slot_r, rd_slot_nxt;
  logic                    pend_r, pend_nxt;
  logic                    hit_r, hit_nxt;
  logic [AW-1:0]           hit_slot_r, hit_slot_nxt;
  logic [AW-1:0]           oldest_r, oldest_nxt;
  logic [CW-1:0]           live_r, live_nxt;
  logic [RET_W-1:0]        ret_r, ret_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic                    out_hit_r, out_hit_nxt;
  logic [PAYLOAD_BITS-1:0] out_pay_r, out_pay_nxt;

  logic                    issue;
  logic                    match;
  logic [KEY_W-1:0]        key_rdata;
  logic [PAYLOAD_BITS-1:0] pay_rdata;
  logic                    full;
  logic [AW:0]             app_sum;
  logic [AW-1:0]           app_slot;
  logic [AW-1:0]           wr_slot;
  logic [LW-1:0]           limit;
  logic                    over;

  assign issue = cmd.scan && (scan_cnt_r != live_r);
  assign match = pend_r && (key_rdata == key_r);
  assign full  = (live_r == CW'(CAPACITY));

  // young end of the ring, wrapped without a modulo
  assign app_sum  = (AW+1)'(oldest_r) + (AW+1)'(live_r);
  assign app_slot = (app_sum >= (AW+1)'(CAPACITY)) ?
                    AW'(app_sum - (AW+1)'(CAPACITY)) : AW'(app_sum);
  assign wr_slot  = hit_r ? hit_slot_r : (full ? oldest_r : app_slot);

  assign limit = (LW'(ret_r) > LW'(CAPACITY)) ? LW'(CAPACITY) : LW'(ret_r);
  assign over  = LW'(live_r) > limit;

  assign sts.mode       = mode_r;
  assign sts.scan_done  = match || (!pend_r && (scan_cnt_r == live_r));
  assign sts.over_limit = over;

  always_comb begin
    mode_nxt      = mode_r;
    key_nxt       = key_r;
    pay_nxt       = pay_r;
    scan_cnt_nxt  = scan_cnt_r;
    scan_ptr_nxt  = scan_ptr_r;
    rd_slot_nxt   = rd_slot_r;
    pend_nxt      = 1'b0;
    hit_nxt       = hit_r;
    hit_slot_nxt  = hit_slot_r;
    oldest_nxt    = oldest_r;
    live_nxt      = live_r;
    ret_nxt       = cfg_we ? cfg_wdata : ret_r;
    out_valid_nxt = cmd.respond;
    out_hit_nxt   = out_hit_r;
    out_pay_nxt   = out_pay_r;

    if (cmd.load) begin
      mode_nxt     = in_mode;
      key_nxt      = in_key;
      pay_nxt      = in_payload[PAYLOAD_BITS-1:0];
      scan_cnt_nxt = '0;
      scan_ptr_nxt = oldest_r;
      hit_nxt      = 1'b0;
    end

    if (issue) begin
      pend_nxt     = 1'b1;
      scan_cnt_nxt = scan_cnt_r + CW'(1);
      scan_ptr_nxt = inc_slot(scan_ptr_r);
      rd_slot_nxt  = scan_ptr_r;
    end

    if (cmd.scan && match) begin
      hit_nxt      = 1'b1;
      hit_slot_nxt = rd_slot_r;
    end

    if (cmd.respond) begin
      out_hit_nxt = match;
      out_pay_nxt = match ? pay_rdata : '0;
    end

    if (cmd.write && !hit_r) begin
      // full ring: the oldest slot is reused and the ring start moves on
      if (full) begin
        oldest_nxt = inc_slot(oldest_r);
      end else begin
        live_nxt = live_r + CW'(1);
      end
    end

    if (cmd.evict && over) begin
      oldest_nxt = inc_slot(oldest_r);
      live_nxt   = live_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= 1'b0;
      hit_r       <= 1'b0;
      oldest_r    <= '0;
      live_r      <= '0;
      ret_r       <= RET_RESET;
      out_valid_r <= 1'b0;
    end else begin
      pend_r      <= pend_nxt;
      hit_r       <= hit_nxt;
      oldest_r    <= oldest_nxt;
      live_r      <= live_nxt;
      ret_r       <= ret_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r     <= mode_nxt;
    key_r      <= key_nxt;
    pay_r      <= pay_nxt;
    scan_cnt_r <= scan_cnt_nxt;
    scan_ptr_r <= scan_ptr_nxt;
    rd_slot_r  <= rd_slot_nxt;
    hit_slot_r <= hit_slot_nxt;
    out_hit_r  <= out_hit_nxt;
    out_pay_r  <= out_pay_nxt;
  end

  fet_ram #(
    .WIDTH (KEY_W),
    .DEPTH (CAPACITY)
  ) u_key_ram (
    .clk   (clk),
    .we    (cmd.write && !hit_r),
    .waddr (wr_slot),
    .wdata (key_r),
    .re    (issue),
    .raddr (scan_ptr_r),
    .rdata (key_rdata)
  );

  fet_ram #(
    .WIDTH (PAYLOAD_BITS),
    .DEPTH (CAPACITY)
  ) u_pay_ram (
    .clk   (clk),
    .we    (cmd.write),
    .waddr (wr_slot),
    .wdata (pay_r),
    .re    (issue),
    .raddr (scan_ptr_r),
    .rdata (pay_rdata)
  );

  assign out_valid = out_valid_r;
  assign out_hit   = out_hit_r;

  always_comb begin
    out_found_payload                   = '0;
    out_found_payload[PAYLOAD_BITS-1:0] = out_pay_r;
  end

endmodule

/* rtl/core/fifo_evicting_feedback_table.sv */
// Bounded key/value table in insertion order. Pulse start while busy is low to
// hand in one item: an insert (in_mode 0) stores or updates in_key/in_payload
// and returns nothing; a lookup (in_mode 1) returns one result, shown for a
// single cycle with out_valid, which the receiver must take then since it
// cannot stall. The key memory has one read port, so every item scans the live
// entries one per cycle, oldest first, until the first match. A lookup strobes
// its result when the scan ends, and busy drops in that same strobe cycle. An
// insert then writes a new key into the ring, or the payload of the matching
// entry on an update, and evicts the oldest entries one at a time while more
// are live than the retention limit (capped at CAPACITY) allows.
// cfg_we writes the retention limit; do so only while idle.
module fifo_evicting_feedback_table #(
  parameter int CAPACITY     = 64,
  parameter int PAYLOAD_BITS = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_mode,
  input  logic [fet_pkg::KEY_W-1:0]     in_key,
  input  logic [fet_pkg::PORT_PL_W-1:0] in_payload,
  output logic                          out_valid,
  output logic                          out_hit,
  output logic [fet_pkg::PORT_PL_W-1:0] out_found_payload,
  input  logic                          cfg_we,
  input  logic [fet_pkg::RET_W-1:0]     cfg_wdata
);
  import fet_pkg::*;

  cmd_t    cmd;
  status_t sts;

  fet_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  fet_dp #(
    .CAPACITY     (CAPACITY),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_mode           (in_mode),
    .in_key            (in_key),
    .in_payload        (in_payload),
    .out_valid         (out_valid),
    .out_hit           (out_hit),
    .out_found_payload (out_found_payload),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata)
  );

endmodule

/* rtl/core/fet_checker.sv */
module fet_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic                          out_valid,
  input logic                          out_hit,
  input logic [fet_pkg::PORT_PL_W-1:0] out_found_payload
);
  import fet_pkg::*;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("transfer accepted but block not busy");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!busy && $past(busy)))
    else $error("result strobe outside end of a lookup");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_hit) |-> (out_found_payload == '0))
    else $error("miss with nonzero payload");

endmodule

bind fifo_evicting_feedback_table fet_checker u_fet_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .out_valid         (out_valid),
  .out_hit           (out_hit),
  .out_found_payload (out_found_payload)
);
